/* sv/mtp_pkg.sv */
package mtp_pkg;

  localparam int unsigned STATE_WORDS_DEF  = 624;
  localparam int unsigned TWIST_OFFSET_DEF = 397;

  localparam logic [31:0] TWIST_XOR = 32'h9908b0df;
  localparam logic [31:0] LOW_BITS  = 32'h7fffffff;
  localparam logic [31:0] HIGH_BIT  = 32'h80000000;
  localparam logic [31:0] TEMPER_B  = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C  = 32'hefc60000;
  localparam logic [31:0] SEED_MULT = 32'd69069;

  localparam logic [1:0] ACT_RAW    = 2'd0;
  localparam logic [1:0] ACT_RANGED = 2'd1;
  localparam logic [1:0] ACT_RESEED = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SEED,
    ST_TW_RD,
    ST_TW_WAIT,
    ST_TW_WR,
    ST_FETCH,
    ST_FETCH_WAIT,
    ST_TEMPER,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic clr_step;
    logic seed_start;
    logic seed_step;
    logic tw_start;
    logic tw_rd;
    logic tw_far;
    logic tw_wr;
    logic fetch_rd;
    logic temper;
    logic div_start;
    logic div_step;
    logic zero_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic seed_last;
    logic tw_last;
    logic idx_full;
    logic div_done;
  } stat_t;

  function automatic logic [31:0] temper_word(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

/* sv/mtp_ctrl.sv */
module mtp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  logic [1:0]      action_i,
  input  logic            range_zero_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  mtp_pkg::stat_t  stat_i,
  output mtp_pkg::cmd_t   cmd_o
);
  import mtp_pkg::*;

  state_e state_q, state_d;
  logic   ranged_q, ranged_d;
  logic   acc;

  assign acc = req_valid_i && req_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      ranged_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ranged_q <= ranged_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    ranged_d = ranged_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          ranged_d = (action_i == ACT_RANGED);
          case (action_i)
            ACT_RAW:    state_d = stat_i.idx_full ? ST_TW_RD : ST_FETCH;
            ACT_RANGED: begin
              if (range_zero_i) state_d = ST_OUT;
              else state_d = stat_i.idx_full ? ST_TW_RD : ST_FETCH;
            end
            ACT_RESEED: state_d = ST_SEED;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR:      if (stat_i.clr_last) state_d = ST_IDLE;
      ST_SEED:       if (stat_i.seed_last) state_d = ST_IDLE;
      ST_TW_RD:      state_d = ST_TW_WAIT;
      ST_TW_WAIT:    state_d = ST_TW_WR;
      ST_TW_WR:      state_d = stat_i.tw_last ? ST_FETCH : ST_TW_RD;
      ST_FETCH:      state_d = ST_FETCH_WAIT;
      ST_FETCH_WAIT: state_d = ST_TEMPER;
      ST_TEMPER:     state_d = ranged_q ? ST_DIV : ST_OUT;
      ST_DIV:        if (stat_i.div_done) state_d = ST_OUT;
      ST_OUT:        if (out_ready_i) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = (state_q == ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          cmd_o.seed_start = (action_i == ACT_RESEED);
          cmd_o.tw_start   = stat_i.idx_full &&
                             ((action_i == ACT_RAW) ||
                              ((action_i == ACT_RANGED) && !range_zero_i));
          cmd_o.zero_out   = (action_i == ACT_RANGED) && range_zero_i;
        end
      end
      ST_CLEAR:      cmd_o.clr_step  = 1'b1;
      ST_SEED:       cmd_o.seed_step = 1'b1;
      ST_TW_RD:      cmd_o.tw_rd     = 1'b1;
      ST_TW_WAIT:    cmd_o.tw_far    = 1'b1;
      ST_TW_WR:      cmd_o.tw_wr     = 1'b1;
      ST_FETCH:      cmd_o.fetch_rd  = 1'b1;
      ST_FETCH_WAIT: cmd_o.temper    = 1'b1;
      ST_TEMPER:     cmd_o.div_start = ranged_q;
      ST_DIV:        cmd_o.div_step  = 1'b1;
      default:       cmd_o           = '0;
    endcase
  end

endmodule

/* sv/mtp_datapath.sv */
module mtp_datapath #(
  parameter int unsigned STATE_WORDS  = mtp_pkg::STATE_WORDS_DEF,
  parameter int unsigned TWIST_OFFSET = mtp_pkg::TWIST_OFFSET_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [31:0]     seed_i,
  input  logic [30:0]     range_i,
  input  logic            req_acc_i,
  input  mtp_pkg::cmd_t   cmd_i,
  output mtp_pkg::stat_t  stat_o,
  output logic [31:0]     value_o
);
  import mtp_pkg::*;

  localparam int unsigned AW = $clog2(STATE_WORDS + 1);
  localparam logic [AW-1:0] LAST = AW'(STATE_WORDS - 1);
  localparam logic [AW-1:0] OFF  = AW'(TWIST_OFFSET);

  logic [31:0] mem_q [STATE_WORDS];
  logic [31:0] rd_q;

  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [31:0]   prev_q, prev_d;
  logic [31:0]   cur_q, cur_d;
  logic [30:0]   rng_q;
  logic [31:0]   tmp_q, tmp_d;
  logic [31:0]   rem_q, rem_d;
  logic [5:0]    cnt_q, cnt_d;
  logic [31:0]   val_q, val_d;

  logic          we;
  logic [31:0]   wd;
  logic [AW-1:0] ra;
  logic [AW-1:0] nxt;
  logic [AW-1:0] far_i;
  logic [31:0]   y, mix;
  logic [32:0]   sh, sub;

  always_comb begin
    nxt   = (ptr_q == LAST) ? '0 : ptr_q + AW'(1);
    far_i = (ptr_q + OFF >= AW'(STATE_WORDS)) ? ptr_q + OFF - AW'(STATE_WORDS)
                                              : ptr_q + OFF;
  end

  // twist reads: next word, then far word; word 0 is read at start
  always_comb begin
    ra = idx_q;
    if (cmd_i.tw_start) ra = '0;
    else if (cmd_i.tw_rd) ra = nxt;
    else if (cmd_i.tw_far) ra = far_i;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[ptr_q] <= wd;
    rd_q <= mem_q[ra];
  end

  always_comb begin
    y   = (prev_q & HIGH_BIT) | (cur_q & LOW_BITS);
    mix = rd_q ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'd0);
    sh  = {rem_q, tmp_q[31]};
    sub = sh - {2'b0, rng_q};
  end

  always_comb begin
    idx_d   = idx_q;
    ptr_d   = ptr_q;
    prev_d  = prev_q;
    cur_d   = cur_q;
    tmp_d   = tmp_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    val_d   = val_q;
    we      = 1'b0;
    wd      = '0;

    if (cmd_i.clr_step) begin
      we    = 1'b1;
      ptr_d = nxt;
    end
    if (cmd_i.seed_start) begin
      ptr_d  = '0;
      prev_d = seed_i;
    end
    if (cmd_i.seed_step) begin
      we     = 1'b1;
      wd     = prev_q;
      prev_d = prev_q * SEED_MULT;
      ptr_d  = nxt;
      idx_d  = AW'(1);
    end
    if (cmd_i.tw_start) begin
      ptr_d = '0;
    end
    if (cmd_i.tw_rd && (ptr_q == '0)) begin
      prev_d = rd_q;
    end
    if (cmd_i.tw_far) begin
      cur_d = rd_q;
    end
    if (cmd_i.tw_wr) begin
      we     = 1'b1;
      wd     = mix;
      prev_d = cur_q;
      ptr_d  = nxt;
      if (ptr_q == LAST) idx_d = '0;
    end
    if (cmd_i.fetch_rd) begin
      idx_d = idx_q + AW'(1);
    end
    if (cmd_i.temper) begin
      val_d = temper_word(rd_q);
      tmp_d = temper_word(rd_q);
    end
    if (cmd_i.div_start) begin
      rem_d = '0;
      cnt_d = '0;
    end
    if (cmd_i.div_step) begin
      tmp_d = {tmp_q[30:0], 1'b0};
      if (!sub[32]) rem_d = sub[31:0];
      else rem_d = sh[31:0];
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) val_d = sub[32] ? sh[31:0] : sub[31:0];
    end
    if (cmd_i.zero_out) val_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= AW'(1);
      ptr_q <= '0;
    end else begin
      idx_q <= idx_d;
      ptr_q <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    cur_q  <= cur_d;
    tmp_q  <= tmp_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
    val_q  <= val_d;
    if (req_acc_i) rng_q <= range_i;
  end

  assign stat_o.clr_last  = cmd_i.clr_step && (ptr_q == LAST);
  assign stat_o.seed_last = cmd_i.seed_step && (ptr_q == LAST);
  assign stat_o.tw_last   = cmd_i.tw_wr && (ptr_q == LAST);
  assign stat_o.idx_full  = (idx_q >= AW'(STATE_WORDS));
  assign stat_o.div_done  = cmd_i.div_step && (cnt_q == 6'd31);
  assign value_o          = val_q;

endmodule

/* sv/mersenne_twister_prng.sv */
// Channel  | Signals                             | Dir
// request  | req_valid_i, req_ready_o, action_i, range_i | in
// result   | out_valid_o, out_ready_i, value_o   | out
// config   | cfg_we_i, cfg_data_i                | in
// One request at a time. Draw: fetch and temper a state word, plus 32
// divide steps for a ranged draw (one restoring step per cycle). Every
// 624th draw first regenerates the state, one read port, each word in
// ST_TW_RD, ST_TW_WAIT, ST_TW_WR. Reseed: one word written per cycle.
// After reset a clearing pass zeroes the state memory.
module mersenne_twister_prng #(
  parameter int unsigned STATE_WORDS  = mtp_pkg::STATE_WORDS_DEF,
  parameter int unsigned TWIST_OFFSET = mtp_pkg::TWIST_OFFSET_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic [1:0]  action_i,
  input  logic [30:0] range_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] value_o
);
  import mtp_pkg::*;

  logic [31:0] seed_q;
  cmd_t        cmd;
  stat_t       stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seed_q <= '0;
    else if (cfg_we_i) seed_q <= cfg_data_i;
  end

  mtp_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .req_valid_i,
    .req_ready_o,
    .action_i,
    .range_zero_i (range_i == '0),
    .out_valid_o,
    .out_ready_i,
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  mtp_datapath #(
    .STATE_WORDS  (STATE_WORDS),
    .TWIST_OFFSET (TWIST_OFFSET)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .seed_i    (seed_q),
    .range_i,
    .req_acc_i (req_valid_i && req_ready_o),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .value_o
  );

endmodule
